>>> rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants of the pairwise distance unit
// Transaction payloads, controller/datapath command and status groups,
// controller states, command codes and configuration register indexes.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int POINT_W    = 6;
  localparam int AXIS_W     = 2;
  localparam int COORD_W    = 16;
  localparam int DIST_W     = 34;
  localparam int PTS_CFG_W  = 7;
  localparam int DIMS_CFG_W = 3;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  localparam logic [PTS_CFG_W-1:0]  PTS_RESET  = 7'd64;
  localparam logic [DIMS_CFG_W-1:0] DIMS_RESET = 3'd2;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Command codes of an input transaction.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ROW  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS   = 1'b1;

  typedef struct packed {
    logic                      command;
    logic [POINT_W-1:0]        point_index;
    logic [AXIS_W-1:0]         axis_index;
    logic signed [COORD_W-1:0] coordinate;
  } in_item_t;

  typedef struct packed {
    logic [POINT_W-1:0] row_index;
    logic [POINT_W-1:0] column_index;
    logic [DIST_W-1:0]  distance;
    logic               last_in_row;
  } out_item_t;

  typedef struct packed {
    logic write;      // store one coordinate
    logic start_row;  // capture row point and counts, clear column counter
    logic fetch;      // read the row point's coordinates
    logic latch_row;  // hold the row point's coordinates
    logic issue;      // read the next column point when the pipeline moves
  } cmd_t;

  typedef struct packed {
    logic adv;         // pipeline moves this cycle
    logic col_last;    // column counter is at the last point in use
    logic pipe_empty;  // no column in flight before the output register
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LATCH,
    ST_RUN,
    ST_DRAIN
  } state_t;

endpackage

>>> rtl/psd_ctrl.sv
// ----------------------------------------------------------------------------
// psd_ctrl: sequencing of load and row transactions
// Accepts input transactions when idle and steps the datapath through the
// row fetch, the column walk and the final drain.
// ----------------------------------------------------------------------------
module psd_ctrl #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DIMS   = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  psd_pkg::in_item_t in_data,
  input  psd_pkg::status_t  status,
  output psd_pkg::cmd_t     cmd
);
  import psd_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   point_ok;
  logic   axis_ok;

  assign point_ok = 32'(in_data.point_index) < MAX_POINTS;
  assign axis_ok  = 32'(in_data.axis_index) < MAX_DIMS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // In the idle state ready is high, so a valid input is an accepted one.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && point_ok) begin
          if (in_data.command == CMD_ROW) begin
            cmd.start_row = 1'b1;
            state_nxt     = ST_FETCH;
          end else if (axis_ok) begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_LATCH;
      end
      ST_LATCH: begin
        cmd.latch_row = 1'b1;
        state_nxt     = ST_RUN;
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (status.adv && status.col_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/psd_datapath.sv
// ----------------------------------------------------------------------------
// psd_datapath: coordinate store and distance pipeline
// One store bank per dimension, read in parallel per column point, then
// difference, square and grouped sum stages, and the final sum with
// saturation ahead of the output register.
// ----------------------------------------------------------------------------
module psd_datapath #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DIMS   = 4,
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  psd_pkg::in_item_t                   in_data,
  input  logic                                cfg_we,
  input  logic [psd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  psd_pkg::cmd_t                       cmd,
  output psd_pkg::status_t                    status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output psd_pkg::out_item_t                  out_data
);
  import psd_pkg::*;

  localparam int PTR_W  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int AX_W   = (MAX_DIMS > 2) ? $clog2(MAX_DIMS) : 1;
  localparam int CNT_W  = (PTS_CFG_W > $clog2(MAX_POINTS + 1)) ?
                          PTS_CFG_W : $clog2(MAX_POINTS + 1);
  localparam int DCNT_W = (DIMS_CFG_W > $clog2(MAX_DIMS + 1)) ?
                          DIMS_CFG_W : $clog2(MAX_DIMS + 1);
  localparam int MAG_W  = COORD_BITS + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int NGRP   = (MAX_DIMS + 3) / 4;
  localparam int GRP_W  = SQ_W + 2;
  localparam int TOT_W  = GRP_W + 2;
  localparam int CMP_W  = (TOT_W > DIST_W) ? TOT_W : DIST_W;

  // Configuration registers.
  logic [PTS_CFG_W-1:0]  cfg_pts_r;
  logic [DIMS_CFG_W-1:0] cfg_dims_r;

  // Coordinate store, one bank per dimension.
  logic [COORD_BITS-1:0] store_mem [MAX_DIMS][MAX_POINTS];
  logic [COORD_BITS-1:0] rd_r      [MAX_DIMS];
  logic [COORD_BITS-1:0] row_c_r   [MAX_DIMS];

  // Row context.
  logic [POINT_W-1:0]  row_idx_r;
  logic [PTR_W-1:0]    row_pt_r;
  logic [PTR_W-1:0]    last_col_r;
  logic [MAX_DIMS-1:0] lane_en_r;
  logic [PTR_W-1:0]    col_r;

  // Pipeline.
  logic                  adv;
  logic                  issue_go;
  logic                  rd_en;
  logic [PTR_W-1:0]      rd_addr;
  logic                  v1_r, v2_r, v3_r, v4_r;
  logic                  last1_r, last2_r, last3_r, last4_r;
  logic [PTR_W-1:0]      col1_r, col2_r, col3_r, col4_r;
  logic [MAG_W-1:0]      mag_r   [MAX_DIMS];
  logic [MAG_W-1:0]      mag_nxt [MAX_DIMS];
  logic [SQ_W-1:0]       sq_r    [MAX_DIMS];
  logic [GRP_W-1:0]      grp_r   [NGRP];
  logic [GRP_W-1:0]      grp_nxt [NGRP];
  logic [TOT_W-1:0]      total;
  logic [CMP_W-1:0]      total_ext;
  logic [DIST_W-1:0]     dist_nxt;
  logic                  out_valid_r;
  out_item_t             out_r;

  // Clamped counts from the configuration registers.
  logic [CNT_W-1:0]      pts_ext;
  logic [CNT_W-1:0]      npts;
  logic [DCNT_W-1:0]     dims_ext;
  logic [DCNT_W-1:0]     ndims;

  always_comb begin
    pts_ext  = CNT_W'(cfg_pts_r);
    dims_ext = DCNT_W'(cfg_dims_r);
    if (pts_ext == '0) begin
      npts = CNT_W'(1);
    end else if (pts_ext > CNT_W'(MAX_POINTS)) begin
      npts = CNT_W'(MAX_POINTS);
    end else begin
      npts = pts_ext;
    end
    if (dims_ext == '0) begin
      ndims = DCNT_W'(1);
    end else if (dims_ext > DCNT_W'(MAX_DIMS)) begin
      ndims = DCNT_W'(MAX_DIMS);
    end else begin
      ndims = dims_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pts_r  <= PTS_RESET;
      cfg_dims_r <= DIMS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_POINTS) begin
        cfg_pts_r <= PTS_CFG_W'(cfg_data);
      end else if (cfg_index == CFG_DIMS) begin
        cfg_dims_r <= DIMS_CFG_W'(cfg_data);
      end
    end
  end

  assign adv      = !out_valid_r || out_ready;
  assign issue_go = cmd.issue && adv;
  assign rd_en    = issue_go || cmd.fetch;
  assign rd_addr  = cmd.fetch ? row_pt_r : col_r;

  // Store write and parallel bank read.
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      store_mem[AX_W'(in_data.axis_index)][PTR_W'(in_data.point_index)] <=
        COORD_BITS'(unsigned'(in_data.coordinate));
    end
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (rd_en) begin
        rd_r[k] <= store_mem[k][rd_addr];
      end
    end
  end

  // Row context and column counter.
  always_ff @(posedge clk) begin
    if (cmd.start_row) begin
      row_idx_r  <= in_data.point_index;
      row_pt_r   <= PTR_W'(in_data.point_index);
      last_col_r <= PTR_W'(npts - CNT_W'(1));
      for (int k = 0; k < MAX_DIMS; k++) begin
        lane_en_r[k] <= DCNT_W'(k) < ndims;
      end
    end
    if (cmd.latch_row) begin
      for (int k = 0; k < MAX_DIMS; k++) begin
        row_c_r[k] <= rd_r[k];
      end
    end
    if (cmd.start_row) begin
      col_r <= '0;
    end else if (issue_go) begin
      col_r <= col_r + PTR_W'(1);
    end
  end

  // Magnitude of each coordinate difference; unused lanes give zero.
  always_comb begin
    for (int k = 0; k < MAX_DIMS; k++) begin
      logic signed [MAG_W-1:0] d;
      d = $signed({row_c_r[k][COORD_BITS-1], row_c_r[k]}) -
          $signed({rd_r[k][COORD_BITS-1], rd_r[k]});
      if (!lane_en_r[k]) begin
        mag_nxt[k] = '0;
      end else if (d[MAG_W-1]) begin
        mag_nxt[k] = MAG_W'(-d);
      end else begin
        mag_nxt[k] = MAG_W'(d);
      end
    end
  end

  // Sums over groups of four lanes.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int l = 0; l < 4; l++) begin
        if (g * 4 + l < MAX_DIMS) begin
          grp_nxt[g] = grp_nxt[g] + GRP_W'(sq_r[g * 4 + l]);
        end
      end
    end
  end

  // Final sum with saturation to the distance width.
  always_comb begin
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      total = total + TOT_W'(grp_r[g]);
    end
    total_ext = CMP_W'(total);
    if (total_ext > CMP_W'(DIST_MAX)) begin
      dist_nxt = DIST_MAX;
    end else begin
      dist_nxt = DIST_W'(total_ext);
    end
  end

  // Pipeline stages, all frozen while the output register is held.
  always_ff @(posedge clk) begin
    if (adv) begin
      col1_r  <= col_r;
      last1_r <= (col_r == last_col_r);
      col2_r  <= col1_r;
      last2_r <= last1_r;
      col3_r  <= col2_r;
      last3_r <= last2_r;
      col4_r  <= col3_r;
      last4_r <= last3_r;
      for (int k = 0; k < MAX_DIMS; k++) begin
        mag_r[k] <= mag_nxt[k];
        sq_r[k]  <= SQ_W'(mag_r[k]) * SQ_W'(mag_r[k]);
      end
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
      out_r.row_index    <= row_idx_r;
      out_r.column_index <= POINT_W'(col4_r);
      out_r.distance     <= dist_nxt;
      out_r.last_in_row  <= last4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= issue_go;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  assign status.adv        = adv;
  assign status.col_last   = (col_r == last_col_r);
  assign status.pipe_empty = !(v1_r || v2_r || v3_r || v4_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // A load never overwrites the store while a row is still being read.
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> !(v1_r || v2_r || v3_r || v4_r))
    else $error("coordinate write while columns are in flight");

  // The row fetch reuses the read register, so no column may be in it.
  a_fetch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |-> !(v1_r || v2_r || v3_r || v4_r))
    else $error("row fetch while columns are in flight");

  // Row coordinates are captured only in the cycle after the fetch.
  a_latch_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch_row |-> $past(cmd.fetch))
    else $error("row latch without a preceding fetch");

  // No column is issued before the row coordinates are held.
  a_issue_order: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(cmd.issue) |-> $past(cmd.latch_row))
    else $error("column walk started without a row latch");
`endif

endmodule

>>> rtl/pairwise_squared_distance_unit.sv
// ----------------------------------------------------------------------------
// pairwise_squared_distance_unit: squared euclidean distance rows
// Holds a store of signed Q8.8 points and, on request, streams the squared
// distance from one point to every point in use, in unsigned Q18.16.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid/in_ready/in_data) carries one command per
// transaction. A load transaction writes one coordinate of one point and
// produces nothing; the next transaction may follow in the cycle after. A row
// transaction for point i produces one result transaction per point j in use,
// j counting up from zero, on the output channel (out_valid/out_ready/
// out_data); the final one has last_in_row set.
// After a row is accepted, the fetch and latch states read and hold the row
// point's coordinates, and the column walk then reads one point per cycle
// from the store banks while the output register is not held, which sets
// the rate. Results pass through the five-stage distance pipeline; the next
// transaction is accepted once no column is left ahead of the output register.
// The configuration port (cfg_we/cfg_index/cfg_data) sets points_in_use and
// dims_in_use; write it only while the block is idle.
// Reset sets points_in_use to 64 and dims_in_use to 2 and clears all control
// state. The store itself is not cleared: a coordinate must be loaded before
// a row reads it. When the receiver holds out_ready low the whole pipeline
// freezes and the pending result stays unchanged on the output register.
// ----------------------------------------------------------------------------
module pairwise_squared_distance_unit #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DIMS   = 4,
  parameter int COORD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  psd_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output psd_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [psd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import psd_pkg::*;

  // Command and status groups between the sequencer and the datapath.
  cmd_t    cmd;
  status_t status;

  // The controller decides when a transaction is taken and walks the row.
  psd_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_DIMS   (MAX_DIMS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the store, the configuration registers, the distance
  // pipeline and the output register.
  psd_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_DIMS   (MAX_DIMS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
